### sv/chip8_instruction_execute_macros.svh
// ----------------------------------------------------------------------------
// CHIP-8 execute core assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CHIP8_INSTRUCTION_EXECUTE_MACROS_SVH
`define CHIP8_INSTRUCTION_EXECUTE_MACROS_SVH

// same-cycle implication
`define C8X_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define C8X_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/c8x_pkg.sv
// ----------------------------------------------------------------------------
// c8x_pkg
// Fixed sizes, request and opcode codes and helpers of the CHIP-8 core.
// ----------------------------------------------------------------------------
package c8x_pkg;

  localparam int MEM_BYTES   = 4096;
  localparam int MEM_AW      = $clog2(MEM_BYTES);
  localparam int STACK_DEPTH = 16;
  localparam int SP_W        = $clog2(STACK_DEPTH);
  localparam int NUM_REGS    = 16;
  localparam int REG_AW      = $clog2(NUM_REGS);

  localparam logic [MEM_AW-1:0] PROG_START_RST = 12'h200;

  // request types
  localparam logic [1:0] REQ_EXEC = 2'd0;
  localparam logic [1:0] REQ_WR   = 2'd1;
  localparam logic [1:0] REQ_RD   = 2'd2;
  localparam logic [1:0] REQ_PIX  = 2'd3;

  // opcode groups (top nibble)
  localparam logic [3:0] OP_SYS   = 4'h0;
  localparam logic [3:0] OP_JP    = 4'h1;
  localparam logic [3:0] OP_CALL  = 4'h2;
  localparam logic [3:0] OP_SEI   = 4'h3;
  localparam logic [3:0] OP_SNEI  = 4'h4;
  localparam logic [3:0] OP_SER   = 4'h5;
  localparam logic [3:0] OP_LDI   = 4'h6;
  localparam logic [3:0] OP_ADDI  = 4'h7;
  localparam logic [3:0] OP_ALU   = 4'h8;
  localparam logic [3:0] OP_SNER  = 4'h9;
  localparam logic [3:0] OP_LDIDX = 4'hA;
  localparam logic [3:0] OP_JPV0  = 4'hB;
  localparam logic [3:0] OP_RND   = 4'hC;
  localparam logic [3:0] OP_DRW   = 4'hD;
  localparam logic [3:0] OP_KEY   = 4'hE;
  localparam logic [3:0] OP_MISC  = 4'hF;

  localparam logic [7:0] SYS_CLS = 8'hE0;
  localparam logic [7:0] SYS_RET = 8'hEE;

  // ALU sub codes
  localparam logic [3:0] ALU_MOV = 4'h0;
  localparam logic [3:0] ALU_OR  = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;
  localparam logic [3:0] ALU_SHR = 4'h6;
  localparam logic [3:0] ALU_SBN = 4'h7;
  localparam logic [3:0] ALU_SHL = 4'hE;

  localparam logic [7:0] KEY_SKP  = 8'h9E;
  localparam logic [7:0] KEY_SKNP = 8'hA1;

  localparam logic [7:0] MISC_GDT  = 8'h07;
  localparam logic [7:0] MISC_WKEY = 8'h0A;
  localparam logic [7:0] MISC_SDT  = 8'h15;
  localparam logic [7:0] MISC_SST  = 8'h18;
  localparam logic [7:0] MISC_AIDX = 8'h1E;
  localparam logic [7:0] MISC_FONT = 8'h29;
  localparam logic [7:0] MISC_BCD  = 8'h33;
  localparam logic [7:0] MISC_STR  = 8'h55;
  localparam logic [7:0] MISC_LDR  = 8'h65;

  // {hundreds, tens, ones}; tens by reciprocal multiply (exact below 100)
  function automatic logic [11:0] bcd_digits(input logic [7:0] v);
    logic [1:0]  h;
    logic [7:0]  rem;
    logic [14:0] prod;
    logic [3:0]  t;
    logic [7:0]  o;
    h    = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
    rem  = v - ((h == 2'd2) ? 8'd200 : ((h == 2'd1) ? 8'd100 : 8'd0));
    prod = 15'(rem) * 15'd205;
    t    = prod[14:11];
    o    = rem - 8'(t) * 8'd10;
    return {2'b00, h, t, o[3:0]};
  endfunction

endpackage

### sv/c8x_if.sv
// ----------------------------------------------------------------------------
// c8x channel interfaces
// Valid/ready channels for requests, results and the configuration write.
// ----------------------------------------------------------------------------
interface c8x_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] opcode;
  logic [15:0] key_state;
  logic [7:0]  random_byte;
  logic [11:0] address;
  logic [7:0]  write_data;

  modport source (output valid, req_type, opcode, key_state, random_byte, address,
                  write_data, input ready);
  modport sink   (input valid, req_type, opcode, key_state, random_byte, address,
                  write_data, output ready);
endinterface

interface c8x_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] pc_value;
  logic [15:0] index_value;
  logic        draw_flag;
  logic [7:0]  delay_value;
  logic [7:0]  sound_value;
  logic [7:0]  read_data;
  logic        key_wait;
  logic        unknown_op;

  modport source (output valid, pc_value, index_value, draw_flag, delay_value,
                  sound_value, read_data, key_wait, unknown_op, input ready);
  modport sink   (input valid, pc_value, index_value, draw_flag, delay_value,
                  sound_value, read_data, key_wait, unknown_op, output ready);
endinterface

interface c8x_cfg_if;
  logic        valid;
  logic        ready;
  logic [11:0] program_start;

  modport source (output valid, program_start, input ready);
  modport sink   (input valid, program_start, output ready);
endinterface

### sv/c8x_ram.sv
// ----------------------------------------------------------------------------
// c8x_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module c8x_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### sv/chip8_instruction_execute.sv
// ----------------------------------------------------------------------------
// chip8_instruction_execute
// CHIP-8 execute core: one request transaction in, one result transaction out.
// ----------------------------------------------------------------------------
// Runs one request at a time. Register reads, ALU ops, jumps, skips, timers and
// memory/pixel requests go from acceptance to the result through two
// data-register reads through the single register-file port, an execute
// step, an optional flag write or memory read and a result step; the core
// then returns to idle for the next request. FX55/FX65 add a register-file
// step and a memory step per register, FX33 adds a memory write per digit,
// 00E0 adds a sweep of the frame buffer (one frame-buffer word per cycle).
// DXYN first wraps the origin by repeated subtraction, then per row fetches
// the sprite byte and steps through its bits, with a pixel read-modify-write
// through the frame-buffer port for each set bit, and at the end closes the
// sprite and writes VF. After reset the core sweeps zeros through memory,
// frame buffer and registers and takes no request meanwhile; configuration
// writes are taken at any time. A finished result sits in the output
// register, so the next request is accepted while it waits.
// ----------------------------------------------------------------------------
`include "chip8_instruction_execute_macros.svh"

module chip8_instruction_execute
  import c8x_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 64,
  parameter int SCREEN_HEIGHT = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  c8x_in_if.sink    in_ch,
  c8x_out_if.source out_ch,
  c8x_cfg_if.sink   cfg_ch
);

  localparam int PIXELS = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int PIX_W  = $clog2(PIXELS);
  localparam int CLR_N  = (PIXELS > MEM_BYTES) ? PIXELS : MEM_BYTES;
  localparam int CLR_W  = $clog2(CLR_N);

  // sequencer states
  localparam logic [4:0] S_INIT  = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_RX    = 5'd2;
  localparam logic [4:0] S_RY    = 5'd3;
  localparam logic [4:0] S_EXEC  = 5'd4;
  localparam logic [4:0] S_MRD   = 5'd5;
  localparam logic [4:0] S_WF    = 5'd6;
  localparam logic [4:0] S_CLS   = 5'd7;
  localparam logic [4:0] S_LDA   = 5'd8;
  localparam logic [4:0] S_LDW   = 5'd9;
  localparam logic [4:0] S_STA   = 5'd10;
  localparam logic [4:0] S_STW   = 5'd11;
  localparam logic [4:0] S_BCD   = 5'd12;
  localparam logic [4:0] S_DMOD  = 5'd13;
  localparam logic [4:0] S_DROW  = 5'd14;
  localparam logic [4:0] S_DBYTE = 5'd15;
  localparam logic [4:0] S_DPR   = 5'd16;
  localparam logic [4:0] S_DPW   = 5'd17;
  localparam logic [4:0] S_DFIN  = 5'd18;
  localparam logic [4:0] S_DONE  = 5'd19;

  // control registers
  logic [4:0]        state_r, state_nxt;
  logic [CLR_W-1:0]  cnt_r, cnt_nxt;
  logic [MEM_AW-1:0] pc_r, pc_nxt;
  logic [15:0]       idx_r, idx_nxt;
  logic [SP_W-1:0]   sp_r, sp_nxt;
  logic [7:0]        dly_r, dly_nxt;
  logic [7:0]        snd_r, snd_nxt;
  logic              out_valid_r, out_valid_nxt;

  // request and work registers (no reset)
  logic [1:0]  req_r, req_nxt;
  logic [15:0] op_r, op_nxt;
  logic [15:0] keys_r, keys_nxt;
  logic [7:0]  rnd_r, rnd_nxt;
  logic [11:0] addr_r, addr_nxt;
  logic [7:0]  wd_r, wd_nxt;
  logic [7:0]  vx_r, vx_nxt;
  logic [7:0]  rdata_r, rdata_nxt;
  logic        draw_r, draw_nxt;
  logic        wait_r, wait_nxt;
  logic        unk_r, unk_nxt;
  logic        flag_r, flag_nxt;
  logic [7:0]  xm_r, xm_nxt;
  logic [7:0]  ym_r, ym_nxt;
  logic [7:0]  col_r, col_nxt;
  logic [7:0]  row_r, row_nxt;
  logic [2:0]  bit_r, bit_nxt;
  logic [3:0]  rcnt_r, rcnt_nxt;
  logic [7:0]  spr_r, spr_nxt;
  logic        coll_r, coll_nxt;

  logic [11:0] o_pc_r;
  logic [15:0] o_idx_r;
  logic        o_draw_r, o_wait_r, o_unk_r;
  logic [7:0]  o_dly_r, o_snd_r, o_rdata_r;

  logic [MEM_AW-1:0] stack_r [STACK_DEPTH];
  logic              stack_we;

  // memory ports
  logic              mem_we;
  logic [MEM_AW-1:0] mem_addr;
  logic [7:0]        mem_wd, mem_q;
  logic              fb_we;
  logic [PIX_W-1:0]  fb_addr;
  logic              fb_wd, fb_q;
  logic              rf_we;
  logic [REG_AW-1:0] rf_addr;
  logic [7:0]        rf_wd, rf_q;

  logic in_fire, out_fire, cfg_fire, out_load;

  // opcode fields
  logic [3:0]  f_grp, f_x, f_y, f_n;
  logic [7:0]  f_nn;
  logic [11:0] f_nnn;
  assign f_grp = op_r[15:12];
  assign f_x   = op_r[11:8];
  assign f_y   = op_r[7:4];
  assign f_n   = op_r[3:0];
  assign f_nn  = op_r[7:0];
  assign f_nnn = op_r[11:0];

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_fire  = in_ch.valid & in_ch.ready;
  assign out_fire = out_ch.valid & out_ch.ready;
  assign cfg_fire = cfg_ch.valid;

  // lowest pressed key
  function automatic logic [3:0] low_key(input logic [15:0] k);
    logic [3:0] r;
    r = 4'd0;
    for (int i = 15; i >= 0; i--) begin
      if (k[i]) r = 4'(i);
    end
    return r;
  endfunction

  logic [11:0] bcd;
  logic [8:0]  sum9;
  logic        pressed;
  logic [PIX_W-1:0] pix;
  logic [MEM_AW-1:0] bulk_addr;
  logic        bulk_last;

  assign bcd       = bcd_digits(vx_r);
  assign sum9      = {1'b0, vx_r} + {1'b0, rf_q};
  assign pressed   = (vx_r[7:4] == 4'd0) && keys_r[vx_r[3:0]];
  assign pix       = PIX_W'(32'(row_r) * 32'(SCREEN_WIDTH) + 32'(col_r));
  assign bulk_addr = idx_r[MEM_AW-1:0] + MEM_AW'(cnt_r[3:0]);
  assign bulk_last = (cnt_r[3:0] == f_x);

  c8x_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
    .clk(clk), .we(mem_we), .addr(mem_addr), .wdata(mem_wd), .rdata(mem_q)
  );

  c8x_ram #(.WIDTH(1), .DEPTH(PIXELS)) u_fb (
    .clk(clk), .we(fb_we), .addr(fb_addr), .wdata(fb_wd), .rdata(fb_q)
  );

  c8x_ram #(.WIDTH(8), .DEPTH(NUM_REGS)) u_rf (
    .clk(clk), .we(rf_we), .addr(rf_addr), .wdata(rf_wd), .rdata(rf_q)
  );

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    pc_nxt     = pc_r;
    idx_nxt    = idx_r;
    sp_nxt     = sp_r;
    dly_nxt    = dly_r;
    snd_nxt    = snd_r;
    req_nxt    = req_r;
    op_nxt     = op_r;
    keys_nxt   = keys_r;
    rnd_nxt    = rnd_r;
    addr_nxt   = addr_r;
    wd_nxt     = wd_r;
    vx_nxt     = vx_r;
    rdata_nxt  = rdata_r;
    draw_nxt   = draw_r;
    wait_nxt   = wait_r;
    unk_nxt    = unk_r;
    flag_nxt   = flag_r;
    xm_nxt     = xm_r;
    ym_nxt     = ym_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    bit_nxt    = bit_r;
    rcnt_nxt   = rcnt_r;
    spr_nxt    = spr_r;
    coll_nxt   = coll_r;
    stack_we   = 1'b0;
    out_load   = 1'b0;
    mem_we     = 1'b0;
    mem_addr   = idx_r[MEM_AW-1:0];
    mem_wd     = 8'd0;
    fb_we      = 1'b0;
    fb_addr    = pix;
    fb_wd      = 1'b0;
    rf_we      = 1'b0;
    rf_addr    = f_x;
    rf_wd      = 8'd0;

    case (state_r)
      S_INIT: begin
        // zero sweep over all three stores
        mem_addr = cnt_r[MEM_AW-1:0];
        mem_we   = (32'(cnt_r) < MEM_BYTES);
        fb_addr  = cnt_r[PIX_W-1:0];
        fb_we    = (32'(cnt_r) < PIXELS);
        rf_addr  = cnt_r[REG_AW-1:0];
        rf_we    = (32'(cnt_r) < NUM_REGS);
        if (cnt_r == CLR_W'(CLR_N - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          req_nxt   = in_ch.req_type;
          op_nxt    = in_ch.opcode;
          keys_nxt  = in_ch.key_state;
          rnd_nxt   = in_ch.random_byte;
          addr_nxt  = in_ch.address;
          wd_nxt    = in_ch.write_data;
          rdata_nxt = 8'd0;
          draw_nxt  = 1'b0;
          wait_nxt  = 1'b0;
          unk_nxt   = 1'b0;
          state_nxt = S_RX;
        end
      end
      S_RX: begin
        rf_addr   = f_x;
        state_nxt = S_RY;
      end
      S_RY: begin
        vx_nxt    = rf_q;
        rf_addr   = (f_grp == OP_JPV0) ? 4'd0 : f_y;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        // rf_q holds Vy (V0 for BNNN)
        state_nxt = S_DONE;
        case (req_r)
          REQ_WR: begin
            mem_addr = addr_r;
            mem_wd   = wd_r;
            mem_we   = 1'b1;
          end
          REQ_RD: begin
            mem_addr  = addr_r;
            state_nxt = S_MRD;
          end
          REQ_PIX: begin
            fb_addr   = PIX_W'(addr_r);
            state_nxt = S_MRD;
          end
          default: begin
            pc_nxt = pc_r + 12'd2;
            case (f_grp)
              OP_SYS: begin
                if (f_nn == SYS_CLS) begin
                  draw_nxt  = 1'b1;
                  cnt_nxt   = '0;
                  state_nxt = S_CLS;
                end else if (f_nn == SYS_RET) begin
                  sp_nxt = sp_r - 1'b1;
                  pc_nxt = stack_r[sp_r - 1'b1] + 12'd2;
                end else begin
                  unk_nxt = 1'b1;
                end
              end
              OP_JP: pc_nxt = f_nnn;
              OP_CALL: begin
                stack_we = 1'b1;
                sp_nxt   = sp_r + 1'b1;
                pc_nxt   = f_nnn;
              end
              OP_SEI:  if (vx_r == f_nn) pc_nxt = pc_r + 12'd4;
              OP_SNEI: if (vx_r != f_nn) pc_nxt = pc_r + 12'd4;
              OP_SER: begin
                if (f_n != 4'd0) unk_nxt = 1'b1;
                else if (vx_r == rf_q) pc_nxt = pc_r + 12'd4;
              end
              OP_LDI: begin
                rf_we = 1'b1;
                rf_wd = f_nn;
              end
              OP_ADDI: begin
                rf_we = 1'b1;
                rf_wd = vx_r + f_nn;
              end
              OP_ALU: begin
                // result here; arith flag next cycle unless x is VF (result wins)
                rf_we = 1'b1;
                if (f_x != 4'hF) state_nxt = S_WF;
                case (f_n)
                  ALU_MOV: begin rf_wd = rf_q;        state_nxt = S_DONE; end
                  ALU_OR:  begin rf_wd = vx_r | rf_q; state_nxt = S_DONE; end
                  ALU_AND: begin rf_wd = vx_r & rf_q; state_nxt = S_DONE; end
                  ALU_XOR: begin rf_wd = vx_r ^ rf_q; state_nxt = S_DONE; end
                  ALU_ADD: begin rf_wd = sum9[7:0];   flag_nxt = sum9[8];      end
                  ALU_SUB: begin rf_wd = vx_r - rf_q; flag_nxt = (vx_r > rf_q); end
                  ALU_SHR: begin rf_wd = {1'b0, vx_r[7:1]}; flag_nxt = vx_r[0]; end
                  ALU_SBN: begin rf_wd = rf_q - vx_r; flag_nxt = (rf_q > vx_r); end
                  ALU_SHL: begin rf_wd = {vx_r[6:0], 1'b0}; flag_nxt = vx_r[7]; end
                  default: begin
                    rf_we     = 1'b0;
                    unk_nxt   = 1'b1;
                    state_nxt = S_DONE;
                  end
                endcase
              end
              OP_SNER: begin
                if (f_n != 4'd0) unk_nxt = 1'b1;
                else if (vx_r != rf_q) pc_nxt = pc_r + 12'd4;
              end
              OP_LDIDX: idx_nxt = {4'd0, f_nnn};
              OP_JPV0:  pc_nxt  = f_nnn + 12'(rf_q);
              OP_RND: begin
                rf_we = 1'b1;
                rf_wd = rnd_r & f_nn;
              end
              OP_DRW: begin
                draw_nxt  = 1'b1;
                xm_nxt    = vx_r;
                ym_nxt    = rf_q;
                coll_nxt  = 1'b0;
                rcnt_nxt  = 4'd0;
                state_nxt = S_DMOD;
              end
              OP_KEY: begin
                if (f_nn == KEY_SKP) begin
                  if (pressed) pc_nxt = pc_r + 12'd4;
                end else if (f_nn == KEY_SKNP) begin
                  if (!pressed) pc_nxt = pc_r + 12'd4;
                end else begin
                  unk_nxt = 1'b1;
                end
              end
              default: begin
                case (f_nn)
                  MISC_GDT: begin
                    rf_we = 1'b1;
                    rf_wd = dly_r;
                  end
                  MISC_WKEY: begin
                    if (keys_r != 16'd0) begin
                      rf_we = 1'b1;
                      rf_wd = {4'd0, low_key(keys_r)};
                    end else begin
                      pc_nxt   = pc_r;
                      wait_nxt = 1'b1;
                    end
                  end
                  MISC_SDT:  dly_nxt = vx_r;
                  MISC_SST:  snd_nxt = vx_r;
                  MISC_AIDX: idx_nxt = idx_r + 16'(vx_r);
                  MISC_FONT: idx_nxt = {6'd0, vx_r, 2'b00} + 16'(vx_r);
                  MISC_BCD: begin
                    cnt_nxt   = '0;
                    state_nxt = S_BCD;
                  end
                  MISC_STR: begin
                    cnt_nxt   = '0;
                    state_nxt = S_STA;
                  end
                  MISC_LDR: begin
                    cnt_nxt   = '0;
                    state_nxt = S_LDA;
                  end
                  default: unk_nxt = 1'b1;
                endcase
              end
            endcase
          end
        endcase
      end
      S_MRD: begin
        if (req_r == REQ_RD) begin
          rdata_nxt = mem_q;
        end else begin
          rdata_nxt = (32'(addr_r) < PIXELS) ? {7'd0, fb_q} : 8'd0;
        end
        state_nxt = S_DONE;
      end
      S_WF: begin
        rf_addr   = 4'hF;
        rf_wd     = {7'd0, flag_r};
        rf_we     = 1'b1;
        state_nxt = S_DONE;
      end
      S_CLS: begin
        fb_addr = cnt_r[PIX_W-1:0];
        fb_we   = 1'b1;
        if (cnt_r == CLR_W'(PIXELS - 1)) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_LDA: begin
        mem_addr  = bulk_addr;
        state_nxt = S_LDW;
      end
      S_LDW: begin
        rf_addr = cnt_r[REG_AW-1:0];
        rf_wd   = mem_q;
        rf_we   = 1'b1;
        if (bulk_last) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_LDA;
        end
      end
      S_STA: begin
        rf_addr   = cnt_r[REG_AW-1:0];
        state_nxt = S_STW;
      end
      S_STW: begin
        mem_addr = bulk_addr;
        mem_wd   = rf_q;
        mem_we   = 1'b1;
        if (bulk_last) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_STA;
        end
      end
      S_BCD: begin
        mem_addr = bulk_addr;
        mem_we   = 1'b1;
        case (cnt_r[1:0])
          2'd0:    mem_wd = {4'd0, bcd[11:8]};
          2'd1:    mem_wd = {4'd0, bcd[7:4]};
          default: mem_wd = {4'd0, bcd[3:0]};
        endcase
        if (cnt_r[1:0] == 2'd2) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DMOD: begin
        // wrap sprite origin into the screen, one subtract per cycle
        if (xm_r >= 8'(SCREEN_WIDTH))  xm_nxt = xm_r - 8'(SCREEN_WIDTH);
        if (ym_r >= 8'(SCREEN_HEIGHT)) ym_nxt = ym_r - 8'(SCREEN_HEIGHT);
        if (xm_r < 8'(SCREEN_WIDTH) && ym_r < 8'(SCREEN_HEIGHT)) begin
          row_nxt   = ym_r;
          state_nxt = S_DROW;
        end
      end
      S_DROW: begin
        mem_addr = idx_r[MEM_AW-1:0] + MEM_AW'(rcnt_r);
        if (rcnt_r == f_n) begin
          state_nxt = S_DFIN;
        end else begin
          state_nxt = S_DBYTE;
        end
      end
      S_DBYTE: begin
        spr_nxt   = mem_q;
        col_nxt   = xm_r;
        bit_nxt   = 3'd0;
        state_nxt = S_DPR;
      end
      S_DPR, S_DPW: begin
        if (state_r == S_DPW) begin
          fb_wd    = ~fb_q;
          fb_we    = 1'b1;
          coll_nxt = coll_r | fb_q;
        end
        if (state_r == S_DPR && spr_r[3'd7 - bit_r]) begin
          state_nxt = S_DPW;
        end else if (bit_r == 3'd7) begin
          rcnt_nxt  = rcnt_r + 1'b1;
          row_nxt   = (row_r == 8'(SCREEN_HEIGHT - 1)) ? 8'd0 : row_r + 8'd1;
          state_nxt = S_DROW;
        end else begin
          bit_nxt   = bit_r + 1'b1;
          col_nxt   = (col_r == 8'(SCREEN_WIDTH - 1)) ? 8'd0 : col_r + 8'd1;
          state_nxt = S_DPR;
        end
      end
      S_DFIN: begin
        rf_addr   = 4'hF;
        rf_wd     = {7'd0, coll_r};
        rf_we     = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // program_start sets PC; user writes only with nothing in flight, unchecked
    if (cfg_fire) begin
      pc_nxt = cfg_ch.program_start;
    end

    if (out_load) out_valid_nxt = 1'b1;
    else if (out_fire) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      cnt_r       <= '0;
      pc_r        <= PROG_START_RST;
      idx_r       <= '0;
      sp_r        <= '0;
      dly_r       <= '0;
      snd_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pc_r        <= pc_nxt;
      idx_r       <= idx_nxt;
      sp_r        <= sp_nxt;
      dly_r       <= dly_nxt;
      snd_r       <= snd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r   <= req_nxt;
    op_r    <= op_nxt;
    keys_r  <= keys_nxt;
    rnd_r   <= rnd_nxt;
    addr_r  <= addr_nxt;
    wd_r    <= wd_nxt;
    vx_r    <= vx_nxt;
    rdata_r <= rdata_nxt;
    draw_r  <= draw_nxt;
    wait_r  <= wait_nxt;
    unk_r   <= unk_nxt;
    flag_r  <= flag_nxt;
    xm_r    <= xm_nxt;
    ym_r    <= ym_nxt;
    col_r   <= col_nxt;
    row_r   <= row_nxt;
    bit_r   <= bit_nxt;
    rcnt_r  <= rcnt_nxt;
    spr_r   <= spr_nxt;
    coll_r  <= coll_nxt;
    if (stack_we) begin
      stack_r[sp_r] <= pc_r;
    end
    if (out_load) begin
      o_pc_r    <= pc_r;
      o_idx_r   <= idx_r;
      o_draw_r  <= draw_r;
      o_dly_r   <= dly_r;
      o_snd_r   <= snd_r;
      o_rdata_r <= rdata_r;
      o_wait_r  <= wait_r;
      o_unk_r   <= unk_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.pc_value    = o_pc_r;
  assign out_ch.index_value = o_idx_r;
  assign out_ch.draw_flag   = o_draw_r;
  assign out_ch.delay_value = o_dly_r;
  assign out_ch.sound_value = o_snd_r;
  assign out_ch.read_data   = o_rdata_r;
  assign out_ch.key_wait    = o_wait_r;
  assign out_ch.unknown_op  = o_unk_r;

  // assertions
  `C8X_ASSERT_NEXT(a_accept_leaves_idle, in_fire, state_r == S_RX,
                   "accepted request did not start the sequence")
  `C8X_ASSERT_NOW(a_no_result_in_init, state_r == S_INIT, !out_valid_r,
                  "result presented during the clearing sweep")
  `C8X_ASSERT_NEXT(a_sp_only_in_exec, state_r != S_EXEC, sp_r == $past(sp_r),
                   "stack pointer moved outside execute")
  `C8X_ASSERT_NEXT(a_pc_only_exec_or_cfg, state_r != S_EXEC && !cfg_fire, $stable(pc_r),
                   "program counter moved without execute or config write")

endmodule

### tb/sv/c8x_exec_checker.sv
// ----------------------------------------------------------------------------
// c8x_exec_checker
// Watches the request, result and configuration channels of the CHIP-8 core,
// keeps its own copy of the machine state and compares every result.
// ----------------------------------------------------------------------------
module c8x_exec_checker
  import c8x_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 64,
  parameter int SCREEN_HEIGHT = 32
) (
  input  logic  clk,
  input  logic  rst_n,
  c8x_in_if     in_ch,
  c8x_out_if    out_ch,
  c8x_cfg_if    cfg_ch,
  output int    fail_count,
  output int    pending_count,
  output int    result_count
);
  localparam int PIXELS = SCREEN_WIDTH * SCREEN_HEIGHT;

  typedef struct packed {
    logic [11:0] pc_value;
    logic [15:0] index_value;
    logic        draw_flag;
    logic [7:0]  delay_value;
    logic [7:0]  sound_value;
    logic [7:0]  read_data;
    logic        key_wait;
    logic        unknown_op;
  } c8x_result_t;

  logic [11:0] start_pc;
  logic [7:0]  vreg [16];
  logic [15:0] idx_reg;
  logic [11:0] pc_reg;
  logic [3:0]  sp_reg;
  logic [11:0] ret_stack [16];
  logic [7:0]  dt_reg, st_reg;
  logic [7:0]  ram [MEM_BYTES];
  logic        fb [PIXELS];
  c8x_result_t expected_results [$];

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("MISMATCH %s: got %0h expected %0h (t=%0t)", what, got, want, $time);
    fail_count++;
  endtask

  task automatic reset_machine();
    start_pc = PROG_START_RST;
    foreach (vreg[i]) vreg[i] = '0;
    foreach (ret_stack[i]) ret_stack[i] = '0;
    foreach (ram[i]) ram[i] = '0;
    foreach (fb[i]) fb[i] = 1'b0;
    idx_reg = '0; pc_reg = start_pc; sp_reg = '0; dt_reg = '0; st_reg = '0;
  endtask

  // Apply one request to the shadow machine and return the predicted result.
  function automatic c8x_result_t execute_request(
      input logic [1:0] req, input logic [15:0] op, input logic [15:0] keys,
      input logic [7:0] rnd, input logic [11:0] addr, input logic [7:0] wdata);
    c8x_result_t res;
    logic [3:0]  x, y, n;
    logic [7:0]  nn, vx, vy, spr;
    logic [11:0] nxt;
    logic        pressed;
    int          k, p;
    res = '0;
    x = op[11:8]; y = op[7:4]; n = op[3:0]; nn = op[7:0];
    vx = vreg[x]; vy = vreg[y];
    nxt = pc_reg + 12'd2;
    if (req == REQ_WR) ram[addr] = wdata;
    else if (req == REQ_RD) res.read_data = ram[addr];
    else if (req == REQ_PIX) res.read_data = (addr < PIXELS) ? {7'd0, fb[addr]} : 8'd0;
    else begin
      case (op[15:12])
        OP_SYS: begin
          if (nn == SYS_CLS) begin
            foreach (fb[i]) fb[i] = 1'b0;
            res.draw_flag = 1'b1;
          end else if (nn == SYS_RET) begin
            // any X nibble returns
            sp_reg = sp_reg - 4'd1;
            nxt = ret_stack[sp_reg] + 12'd2;
          end else res.unknown_op = 1'b1;
        end
        OP_JP: nxt = op[11:0];
        OP_CALL: begin
          ret_stack[sp_reg] = pc_reg;
          sp_reg = sp_reg + 4'd1;
          nxt = op[11:0];
        end
        OP_SEI:  if (vx == nn) nxt += 12'd2;
        OP_SNEI: if (vx != nn) nxt += 12'd2;
        OP_SER: begin
          if (n != 4'd0) res.unknown_op = 1'b1;
          else if (vx == vy) nxt += 12'd2;
        end
        OP_LDI:  vreg[x] = nn;
        OP_ADDI: vreg[x] = vx + nn;
        OP_ALU: begin
          // flag first, so the result wins when x is 15
          case (n)
            ALU_MOV: vreg[x] = vy;
            ALU_OR:  vreg[x] = vx | vy;
            ALU_AND: vreg[x] = vx & vy;
            ALU_XOR: vreg[x] = vx ^ vy;
            ALU_ADD: begin vreg[15] = ({1'b0, vx} + vy) > 9'hFF; vreg[x] = vx + vy; end
            ALU_SUB: begin vreg[15] = vx > vy; vreg[x] = vx - vy; end
            ALU_SHR: begin vreg[15] = vx[0]; vreg[x] = vx >> 1; end
            ALU_SBN: begin vreg[15] = vy > vx; vreg[x] = vy - vx; end
            ALU_SHL: begin vreg[15] = vx[7]; vreg[x] = vx << 1; end
            default: res.unknown_op = 1'b1;
          endcase
        end
        OP_SNER: begin
          if (n != 4'd0) res.unknown_op = 1'b1;
          else if (vx != vy) nxt += 12'd2;
        end
        OP_LDIDX: idx_reg = {4'd0, op[11:0]};
        OP_JPV0:  nxt = op[11:0] + vreg[0];
        OP_RND:   vreg[x] = rnd & nn;
        OP_DRW: begin
          vreg[15] = 8'd0;
          for (int r = 0; r < n; r++) begin
            spr = ram[12'(idx_reg + r)];
            for (int c = 0; c < 8; c++) if (spr[7-c]) begin
              p = ((int'(vy) + r) % SCREEN_HEIGHT) * SCREEN_WIDTH
                  + ((int'(vx) + c) % SCREEN_WIDTH);
              if (fb[p]) vreg[15] = 8'd1;
              fb[p] = ~fb[p];
            end
          end
          res.draw_flag = 1'b1;
        end
        OP_KEY: begin
          pressed = (vx < 16) && keys[vx[3:0]];
          if (nn == KEY_SKP) begin if (pressed) nxt += 12'd2; end
          else if (nn == KEY_SKNP) begin if (!pressed) nxt += 12'd2; end
          else res.unknown_op = 1'b1;
        end
        default: begin
          case (nn)
            MISC_GDT: vreg[x] = dt_reg;
            MISC_WKEY: begin
              k = 16;
              for (int i = 15; i >= 0; i--) if (keys[i]) k = i;
              if (k < 16) vreg[x] = 8'(k);
              else begin nxt = pc_reg; res.key_wait = 1'b1; end
            end
            MISC_SDT:  dt_reg = vx;
            MISC_SST:  st_reg = vx;
            MISC_AIDX: idx_reg = idx_reg + vx;
            MISC_FONT: idx_reg = 16'(vx) * 16'd5;
            MISC_BCD: begin
              ram[12'(idx_reg)]      = vx / 100;
              ram[12'(idx_reg + 1)]  = (vx / 10) % 10;
              ram[12'(idx_reg + 2)]  = vx % 10;
            end
            MISC_STR: for (int i = 0; i <= x; i++) ram[12'(idx_reg + i)] = vreg[i];
            MISC_LDR: for (int i = 0; i <= x; i++) vreg[i] = ram[12'(idx_reg + i)];
            default: res.unknown_op = 1'b1;
          endcase
        end
      endcase
      pc_reg = nxt;
    end
    res.pc_value = pc_reg;
    res.index_value = idx_reg;
    res.delay_value = dt_reg;
    res.sound_value = st_reg;
    return res;
  endfunction

  always @(posedge clk) begin
    c8x_result_t want;
    if (!rst_n) begin
      reset_machine();
      expected_results.delete();
      fail_count = 0; result_count = 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        start_pc = cfg_ch.program_start;
        pc_reg = start_pc;
      end
      // the result is compared before the request of the same edge is predicted
      if (out_ch.valid && out_ch.ready) begin
        result_count++;
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing pending", 16'h0, 16'h0);
        end else begin
          want = expected_results.pop_front();
          if (out_ch.pc_value !== want.pc_value)
            report_mismatch("pc_value", out_ch.pc_value, want.pc_value);
          if (out_ch.index_value !== want.index_value)
            report_mismatch("index_value", out_ch.index_value, want.index_value);
          if (out_ch.draw_flag !== want.draw_flag)
            report_mismatch("draw_flag", out_ch.draw_flag, want.draw_flag);
          if (out_ch.delay_value !== want.delay_value)
            report_mismatch("delay_value", out_ch.delay_value, want.delay_value);
          if (out_ch.sound_value !== want.sound_value)
            report_mismatch("sound_value", out_ch.sound_value, want.sound_value);
          if (out_ch.read_data !== want.read_data)
            report_mismatch("read_data", out_ch.read_data, want.read_data);
          if (out_ch.key_wait !== want.key_wait)
            report_mismatch("key_wait", out_ch.key_wait, want.key_wait);
          if (out_ch.unknown_op !== want.unknown_op)
            report_mismatch("unknown_op", out_ch.unknown_op, want.unknown_op);
        end
      end
      if (in_ch.valid && in_ch.ready)
        expected_results.push_back(execute_request(in_ch.req_type, in_ch.opcode,
          in_ch.key_state, in_ch.random_byte, in_ch.address, in_ch.write_data));
    end
    pending_count = expected_results.size();
  end
endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives requests and program-start writes into the CHIP-8 execute core,
// stalls the result side, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench;
  import c8x_pkg::*;

  localparam int  TIMEOUT_CYCLES = 10_000_000;
  localparam int  DRAIN_CYCLES   = 3000;   // longer than a full clear-screen pass

  logic clk;
  logic rst_n;
  int   fail_count, pending_count, result_count;
  int   cycle_count;
  int   sent_count;
  bit   hold_off;     // long receiver stall requested by stimulus
  logic [3:0] call_depth;   // tracked so a return never pops an unwritten entry

  c8x_in_if  in_ch ();
  c8x_out_if out_ch ();
  c8x_cfg_if cfg_ch ();

  chip8_instruction_execute u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  c8x_exec_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_ch        (cfg_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .result_count  (result_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: even if every item were a full clear screen under the longest
  // stalls, the run stays well below this limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > TIMEOUT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver: random stall pattern, occasional stall-free stretches,
  // and a long hold-off when stimulus asks for one.
  initial begin
    int mode;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      mode = (cycle_count / 500) % 4;
      if (hold_off) out_ch.ready <= 1'b0;
      else if (mode == 0) out_ch.ready <= 1'b1;
      else if (mode == 1) out_ch.ready <= ($urandom_range(0, 3) != 0);
      else if (mode == 2) out_ch.ready <= ($urandom_range(0, 3) == 0);
      else out_ch.ready <= $urandom_range(0, 1);
    end
  end

  // Drive one request transaction and wait for acceptance.
  task automatic send_request(input logic [1:0] req, input logic [15:0] op,
                              input logic [15:0] keys = 16'h0,
                              input logic [11:0] addr = 12'h0,
                              input logic [7:0] wdata = 8'h0);
    in_ch.valid       <= 1'b1;
    in_ch.req_type    <= req;
    in_ch.opcode      <= op;
    in_ch.key_state   <= keys;
    in_ch.random_byte <= 8'($urandom);
    in_ch.address     <= addr;
    in_ch.write_data  <= wdata;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    sent_count++;
    // stack bookkeeping
    if (req == REQ_EXEC && op[15:12] == OP_CALL) call_depth++;
    if (req == REQ_EXEC && op[15:12] == OP_SYS && op[7:0] == SYS_RET) call_depth--;
  endtask

  task automatic exec_op(input logic [15:0] op, input logic [15:0] keys = 16'h0);
    send_request(REQ_EXEC, op, keys);
  endtask

  // Gap between bursts; valid drops only when a gap is taken.
  task automatic maybe_gap(inout int burst_left);
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    in_ch.valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(negedge clk);
    burst_left = $urandom_range(0, 20);
  endtask

  // Wait until every result is in, plus settling time for the block.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_program_start(input logic [11:0] value);
    cfg_ch.valid         <= 1'b1;
    cfg_ch.program_start <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    call_depth = '0;   // stack pointer is untouched, but old entries stay valid
  endtask

  // Random opcode, mostly well-formed, occasionally noise.
  function automatic logic [15:0] random_opcode(input int sel);
    logic [3:0] x, y;
    logic [7:0] nn;
    logic [7:0] misc [9];
    logic [3:0] alu  [9];
    misc = '{MISC_GDT, MISC_WKEY, MISC_SDT, MISC_SST, MISC_AIDX, MISC_FONT,
             MISC_BCD, MISC_STR, MISC_LDR};
    alu  = '{ALU_MOV, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD, ALU_SUB, ALU_SHR,
             ALU_SBN, ALU_SHL};
    x = 4'($urandom); y = 4'($urandom); nn = 8'($urandom);
    case (sel)
      0:  return {OP_SYS, 4'h0, SYS_CLS};
      1:  return {OP_JP, 12'($urandom)};
      2:  return {OP_SEI, x, nn};
      3:  return {OP_SNEI, x, nn};
      4:  return {OP_SER, x, y, 4'h0};
      5:  return {OP_LDI, x, nn};
      6:  return {OP_ADDI, x, nn};
      7:  return {OP_ALU, x, y, alu[$urandom_range(0, 8)]};
      8:  return {OP_SNER, x, y, 4'h0};
      9:  return {OP_LDIDX, 12'($urandom)};
      10: return {OP_JPV0, 12'($urandom)};
      11: return {OP_RND, x, nn};
      12: return {OP_DRW, x, y, 4'($urandom_range(0, 15))};
      13: return {OP_KEY, x, ($urandom_range(0, 1) ? KEY_SKP : KEY_SKNP)};
      14: return {OP_MISC, x, misc[$urandom_range(0, 8)]};
      15: return {OP_ALU, x, y, alu[$urandom_range(0, 8)]};
      default: return 16'($urandom);   // noise, usually unknown or odd codes
    endcase
  endfunction

  initial begin
    int burst_left;
    int sel;
    logic [15:0] op;
    logic [1:0]  req;
    rst_n = 1'b0;
    cycle_count = 0; sent_count = 0; hold_off = 1'b0;
    call_depth = '0; burst_left = 0;
    in_ch.valid = 1'b0; in_ch.req_type = REQ_EXEC; in_ch.opcode = '0;
    in_ch.key_state = '0; in_ch.random_byte = '0; in_ch.address = '0;
    in_ch.write_data = '0;
    cfg_ch.valid = 1'b0; cfg_ch.program_start = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // --- directed part ---
    write_program_start(12'hFFE);                 // PC wraps on next advance
    exec_op({OP_LDI, 4'h1, 8'hFF});
    exec_op({OP_LDI, 4'h2, 8'h01});
    exec_op({OP_ALU, 4'h1, 4'h2, ALU_ADD});       // carry out
    exec_op({OP_LDI, 4'hF, 8'h80});
    exec_op({OP_ALU, 4'hF, 4'h2, ALU_SHL});       // result beats flag in VF
    exec_op({OP_ALU, 4'h2, 4'h1, ALU_SUB});       // no borrow
    exec_op({OP_CALL, 12'hABC});
    exec_op({OP_SYS, 4'h0, SYS_RET});
    exec_op({OP_LDIDX, 12'hFFE});
    exec_op({OP_MISC, 4'h1, MISC_BCD});           // address wraps past 0xFFF
    exec_op({OP_MISC, 4'hF, MISC_STR});
    exec_op({OP_MISC, 4'hF, MISC_LDR});
    exec_op({OP_LDI, 4'h3, 8'h3F});
    exec_op({OP_LDI, 4'h4, 8'h1F});
    exec_op({OP_DRW, 4'h3, 4'h4, 4'hF});          // sprite wraps both axes
    exec_op({OP_DRW, 4'h3, 4'h4, 4'h1});          // redraw of a zero sprite row, no collision
    send_request(REQ_PIX, 16'h0, 16'h0, 12'hFFF); // pixel index out of range
    send_request(REQ_PIX, 16'h0, 16'h0, 12'd2047);
    exec_op({OP_MISC, 4'h5, MISC_WKEY}, 16'h0);   // no key: PC held
    exec_op({OP_MISC, 4'h5, MISC_WKEY}, 16'h8000);
    exec_op({OP_LDI, 4'h1, 8'hFF});
    exec_op({OP_KEY, 4'h1, KEY_SKP}, 16'hFFFF);   // key index above 15
    exec_op({OP_SYS, 4'h1, 8'h23});               // unknown system call
    exec_op({OP_SER, 4'h1, 4'h2, 4'h7});          // unknown skip variant
    exec_op({OP_SYS, 4'h0, SYS_CLS});
    drain();

    // --- random phases, each under its own program start ---
    for (int phase = 0; phase < 4; phase++) begin
      write_program_start(phase == 0 ? 12'h000 : phase == 1 ? 12'hFFF
                          : 12'($urandom));
      for (int i = 0; i < 250; i++) begin
        // one long stall per phase while requests keep coming
        if (i == 60) begin
          hold_off = 1'b1;
          fork
            begin repeat (400) @(negedge clk); hold_off = 1'b0; end
          join_none
        end
        sel = $urandom_range(0, 19);
        req = REQ_EXEC;
        if (sel >= 17) req = 2'($urandom_range(1, 3));
        op = random_opcode(sel == 16 ? 16 : $urandom_range(1, 15));
        // clear screen rarely: it costs a full frame-buffer sweep
        if ($urandom_range(0, 60) == 0) op = {OP_SYS, 4'h0, SYS_CLS};
        if ($urandom_range(0, 9) == 0) op = {OP_CALL, 12'($urandom)};
        // only return through an entry written since the last config write
        if (op[15:12] == OP_SYS && op[7:0] == SYS_RET && call_depth == 0)
          op = {OP_CALL, op[11:0]};
        if (op[15:12] == OP_SYS && op[7:0] == SYS_RET && op[11:8] != 0 &&
            call_depth == 0) op = {OP_CALL, op[11:0]};
        if ($urandom_range(0, 6) == 0 && call_depth != 0)
          op = {OP_SYS, 4'h0, SYS_RET};
        send_request(req, op, 16'($urandom) & (($urandom_range(0, 3) == 0) ? 16'h0
                     : 16'hFFFF), 12'($urandom), 8'($urandom));
        maybe_gap(burst_left);
      end
      drain();
    end

    $display("covered %0d requests and %0d results over 5 program-start settings",
             sent_count, result_count);
    $display("including wraps, stack calls, sprite collisions and a long output stall");
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

### chip8_instruction_execute.f
+incdir+sv
sv/c8x_pkg.sv
sv/c8x_if.sv
sv/c8x_ram.sv
sv/chip8_instruction_execute.sv
tb/sv/c8x_exec_checker.sv
tb/sv/testbench.sv
